// File: rtl/plst_pkg.sv
package plst_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [LEN_W-1:0] len_type;

   typedef enum logic [2:0] {
      KIND_INSERT_FRONT = 3'd0,
      KIND_INSERT_AT    = 3'd1,
      KIND_INSERT_END   = 3'd2,
      KIND_DELETE_FRONT = 3'd3,
      KIND_DELETE_AT    = 3'd4,
      KIND_DELETE_END   = 3'd5,
      KIND_READ_OUT     = 3'd6,
      KIND_CLEAR        = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PLACE_FRONT = 2'd0,
      PLACE_AT    = 2'd1,
      PLACE_END   = 2'd2
   } place_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_READ = 1'b1
   } bk_state_type;

   typedef struct packed {
      kind_type                  kind;
      logic [4:0]                position;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  element;
      idx_type                   element_index;
      len_type                   length;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      op_type                    op;
      place_type                 place;
      logic [4:0]                position;
      logic signed [DATA_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_port_type;

endpackage

// File: rtl/positional_list_store.sv
// Bounded ordered list of signed 32-bit values held in shift cells.
// Request channel: drive req and raise start; the request is taken at a
// rising edge where start is high and busy is low. Busy rises while the
// two-entry command queue between the front end and the executor is full.
// Response channel: each response sits on rsp for one cycle with rsp_valid
// high; the receiver cannot stall it and must take it in that cycle.
// Insert, delete and clear give one response each: the request waits in the
// command queue and the executor registers its response when it takes it.
// These run at one request per cycle while no read out holds the executor.
// Read out gives one response per element, one per cycle, with last on the
// final one (one empty response for an empty list), and holds the executor.
// An error (empty, out of range, full) leaves the list unchanged.
// Reset empties the list and the queue and drops any pending response;
// no clearing pass is needed, as entries beyond the length are never read.
module positional_list_store (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  plst_pkg::req_type  req,
   output logic               rsp_valid,
   output plst_pkg::rsp_type  rsp
);

   logic                    queue_full;
   logic                    push;
   plst_pkg::cmd_type       push_cmd;
   logic                    pop;
   plst_pkg::cmd_port_type  head;

   plst_front u_front (
      .start      (start),
      .req        (req),
      .queue_full (queue_full),
      .busy       (busy),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   plst_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (queue_full),
      .head     (head)
   );

   plst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

// File: rtl/plst_front.sv
module plst_front (
   input  logic               start,
   input  plst_pkg::req_type  req,
   input  logic               queue_full,
   output logic               busy,
   output logic               push,
   output plst_pkg::cmd_type  push_cmd
);

   assign busy = queue_full;
   assign push = start && !queue_full;

   always_comb begin
      push_cmd.position = req.position;
      push_cmd.value    = req.value;
      push_cmd.op       = plst_pkg::OP_CLEAR;
      push_cmd.place    = plst_pkg::PLACE_FRONT;
      case (req.kind)
         plst_pkg::KIND_INSERT_FRONT: begin
            push_cmd.op    = plst_pkg::OP_INSERT;
            push_cmd.place = plst_pkg::PLACE_FRONT;
         end
         plst_pkg::KIND_INSERT_AT: begin
            push_cmd.op    = plst_pkg::OP_INSERT;
            push_cmd.place = plst_pkg::PLACE_AT;
         end
         plst_pkg::KIND_INSERT_END: begin
            push_cmd.op    = plst_pkg::OP_INSERT;
            push_cmd.place = plst_pkg::PLACE_END;
         end
         plst_pkg::KIND_DELETE_FRONT: begin
            push_cmd.op    = plst_pkg::OP_DELETE;
            push_cmd.place = plst_pkg::PLACE_FRONT;
         end
         plst_pkg::KIND_DELETE_AT: begin
            push_cmd.op    = plst_pkg::OP_DELETE;
            push_cmd.place = plst_pkg::PLACE_AT;
         end
         plst_pkg::KIND_DELETE_END: begin
            push_cmd.op    = plst_pkg::OP_DELETE;
            push_cmd.place = plst_pkg::PLACE_END;
         end
         plst_pkg::KIND_READ_OUT: begin
            push_cmd.op    = plst_pkg::OP_READ;
         end
         default: begin
            push_cmd.op    = plst_pkg::OP_CLEAR;
         end
      endcase
   end

endmodule

// File: rtl/plst_queue.sv
module plst_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  plst_pkg::cmd_type       push_cmd,
   input  logic                    pop,
   output logic                    full,
   output plst_pkg::cmd_port_type  head
);

   plst_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head.valid = (fill_ff != 2'd0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/plst_back.sv
module plst_back (
   input  logic                    clock,
   input  logic                    reset,
   input  plst_pkg::cmd_port_type  head,
   output logic                    pop,
   output logic                    rsp_valid,
   output plst_pkg::rsp_type       rsp
);

   logic signed [plst_pkg::DATA_W-1:0] entries_ff [plst_pkg::CAPACITY];
   logic signed [plst_pkg::DATA_W-1:0] entries_in [plst_pkg::CAPACITY];
   plst_pkg::len_type       count_ff, count_in;
   plst_pkg::idx_type       idx_ff, idx_in;
   plst_pkg::bk_state_type  state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   plst_pkg::rsp_type       rsp_ff, rsp_in;
   plst_pkg::len_type       ins_pos;
   plst_pkg::len_type       del_pos;
   logic                    read_done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign read_done = ({1'b0, idx_ff} == count_ff - plst_pkg::len_type'(1));

   always_comb begin
      case (head.cmd.place)
         plst_pkg::PLACE_FRONT: begin
            ins_pos = '0;
            del_pos = '0;
         end
         plst_pkg::PLACE_END: begin
            ins_pos = count_ff;
            del_pos = count_ff - plst_pkg::len_type'(1);
         end
         default: begin
            ins_pos = head.cmd.position;
            del_pos = head.cmd.position;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         plst_pkg::BK_IDLE: begin
            if (head.valid && head.cmd.op == plst_pkg::OP_READ
                && count_ff > plst_pkg::len_type'(1)) begin
               state_in = plst_pkg::BK_READ;
            end
         end
         plst_pkg::BK_READ: begin
            if (read_done) begin
               state_in = plst_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = plst_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      entries_in           = entries_ff;
      count_in             = count_ff;
      idx_in               = idx_ff;
      pop                  = 1'b0;
      rsp_valid_in         = 1'b0;
      rsp_in.status        = plst_pkg::STATUS_OK;
      rsp_in.element       = '0;
      rsp_in.element_index = '0;
      rsp_in.length        = count_ff;
      rsp_in.last          = 1'b1;
      case (state_ff)
         plst_pkg::BK_IDLE: begin
            if (head.valid) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               case (head.cmd.op)
                  plst_pkg::OP_INSERT: begin
                     if (ins_pos > count_ff) begin
                        rsp_in.status = plst_pkg::STATUS_RANGE;
                     end else if (count_ff ==
                                  plst_pkg::len_type'(plst_pkg::CAPACITY)) begin
                        rsp_in.status = plst_pkg::STATUS_FULL;
                     end else begin
                        if (ins_pos == '0) begin
                           entries_in[0] = head.cmd.value;
                        end
                        for (int i = 1; i < plst_pkg::CAPACITY; i++) begin
                           if (plst_pkg::len_type'(i) == ins_pos) begin
                              entries_in[i] = head.cmd.value;
                           end else if (plst_pkg::len_type'(i) > ins_pos) begin
                              entries_in[i] = entries_ff[i-1];
                           end
                        end
                        count_in      = count_ff + plst_pkg::len_type'(1);
                        rsp_in.length = count_in;
                     end
                  end
                  plst_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = plst_pkg::STATUS_EMPTY;
                     end else if (del_pos >= count_ff) begin
                        rsp_in.status = plst_pkg::STATUS_RANGE;
                     end else begin
                        for (int i = 0; i < plst_pkg::CAPACITY - 1; i++) begin
                           if (plst_pkg::len_type'(i) >= del_pos) begin
                              entries_in[i] = entries_ff[i+1];
                           end
                        end
                        count_in      = count_ff - plst_pkg::len_type'(1);
                        rsp_in.length = count_in;
                     end
                  end
                  plst_pkg::OP_READ: begin
                     if (count_ff == '0) begin
                        rsp_in.status = plst_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_in.element = entries_ff[0];
                        rsp_in.last    = (count_ff == plst_pkg::len_type'(1));
                        idx_in         = plst_pkg::idx_type'(1);
                     end
                  end
                  default: begin
                     count_in      = '0;
                     rsp_in.length = '0;
                  end
               endcase
            end
         end
         plst_pkg::BK_READ: begin
            rsp_valid_in         = 1'b1;
            rsp_in.element       = entries_ff[idx_ff];
            rsp_in.element_index = idx_ff;
            rsp_in.last          = read_done;
            idx_in               = idx_ff + plst_pkg::idx_type'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plst_pkg::BK_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      rsp_ff     <= rsp_in;
   end

endmodule

// File: tb/list_checker.sv
module list_checker
   import plst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req,
   input  logic    rsp_valid,
   input  rsp_type rsp,
   output int      failures,
   output int      outstanding
);

   logic signed [DATA_W-1:0] cells [CAPACITY];
   int unsigned              fill;
   rsp_type                  due_rsp [$];
   rsp_type                  want;

   function automatic rsp_type make_rsp(status_type s, logic signed [DATA_W-1:0] e,
                                        int unsigned i, int unsigned n, logic l);
      rsp_type r;
      r.status        = s;
      r.element       = e;
      r.element_index = idx_type'(i);
      r.length        = len_type'(n);
      r.last          = l;
      return r;
   endfunction

   function automatic status_type insert_cell(int unsigned at, logic signed [DATA_W-1:0] v);
      if (at > fill) return STATUS_RANGE;
      if (fill >= CAPACITY) return STATUS_FULL;
      for (int unsigned i = fill; i > at; i--) cells[i] = cells[i-1];
      cells[at] = v;
      fill++;
      return STATUS_OK;
   endfunction

   function automatic status_type delete_cell(int unsigned at);
      if (fill == 0) return STATUS_EMPTY;
      if (at >= fill) return STATUS_RANGE;
      for (int unsigned i = at; i + 1 < fill; i++) cells[i] = cells[i+1];
      fill--;
      return STATUS_OK;
   endfunction

   task automatic predict_list_op(req_type r);
      status_type s;
      s = STATUS_OK;
      case (r.kind)
         KIND_INSERT_FRONT: s = insert_cell(0, r.value);
         KIND_INSERT_AT:    s = insert_cell(r.position, r.value);
         KIND_INSERT_END:   s = insert_cell(fill, r.value);
         KIND_DELETE_FRONT: s = delete_cell(0);
         KIND_DELETE_AT:    s = delete_cell(r.position);
         KIND_DELETE_END: begin
            if (fill == 0) s = STATUS_EMPTY;
            else s = delete_cell(fill - 1);
         end
         KIND_READ_OUT: ;
         default: fill = 0;
      endcase
      if (r.kind != KIND_READ_OUT) begin
         due_rsp.push_back(make_rsp(s, '0, 0, fill, 1'b1));
      end else if (fill == 0) begin
         due_rsp.push_back(make_rsp(STATUS_EMPTY, '0, 0, 0, 1'b1));
      end else begin
         for (int unsigned i = 0; i < fill; i++)
            due_rsp.push_back(make_rsp(STATUS_OK, cells[i], i, fill, i + 1 == fill));
      end
   endtask

   task automatic note_failure(string what, rsp_type exp_rsp, rsp_type got);
      if (failures < 10) begin
         $display("%t %s: expected status %0d element %0d index %0d length %0d last %0d",
                  $realtime, what, exp_rsp.status, exp_rsp.element, exp_rsp.element_index,
                  exp_rsp.length, exp_rsp.last);
         $display("%t %s: actual   status %0d element %0d index %0d length %0d last %0d",
                  $realtime, what, got.status, got.element, got.element_index,
                  got.length, got.last);
      end
      failures++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill = 0;
         due_rsp.delete();
      end else begin
         if (start && !busy) predict_list_op(req);
         if (rsp_valid) begin
            if (due_rsp.size() == 0) begin
               note_failure("unexpected response", 'x, rsp);
            end else begin
               want = due_rsp.pop_front();
               if (rsp.status !== want.status || rsp.element !== want.element ||
                   rsp.element_index !== want.element_index ||
                   rsp.length !== want.length || rsp.last !== want.last)
                  note_failure("response mismatch", want, rsp);
            end
         end
      end
      outstanding = due_rsp.size();
   end

endmodule

// File: tb/testbench.sv
module testbench;
   import plst_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 110;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req   = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp;
   int      failures;
   int      outstanding;
   int      cycles = 0;
   int      sent = 0;
   bit      no_gaps = 1'b0;

   positional_list_store dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   list_checker list_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic idle_gap();
      int g;
      g = 0;
      if (!no_gaps) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: g = 0;
            6, 7, 8: g = $urandom_range(1, 3);
            default: g = $urandom_range(10, 40);
         endcase
      end
      if (g > 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send(kind_type k, int p, logic signed [DATA_W-1:0] v);
      start <= 1'b1;
      req   <= '{kind: k, position: 5'(p), value: v};
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
      idle_gap();
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic build_list(int n);
      send(KIND_CLEAR, $urandom_range(0, 31), pick_value());
      repeat (n) send(KIND_INSERT_END, $urandom_range(0, 31), pick_value());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(KIND_READ_OUT, 0, 0);
      send(KIND_DELETE_FRONT, 0, 0);
      send(KIND_DELETE_AT, 0, 0);
      send(KIND_DELETE_END, 0, 0);
      send(KIND_INSERT_AT, 1, 5);
      send(KIND_INSERT_AT, 31, -1);
      send(KIND_INSERT_FRONT, 0, 32'h7fff_ffff);
      send(KIND_INSERT_END, 0, 32'h8000_0000);
      send(KIND_INSERT_AT, 1, 0);
      send(KIND_INSERT_AT, 3, -1);
      send(KIND_INSERT_AT, 4, 7);
      send(KIND_READ_OUT, 0, 0);
      send(KIND_DELETE_AT, 3, 0);
      send(KIND_DELETE_AT, 31, 0);
      send(KIND_DELETE_AT, 1, 0);
      send(KIND_DELETE_END, 0, 0);
      send(KIND_DELETE_FRONT, 0, 0);
      send(KIND_READ_OUT, 0, 0);
      send(KIND_CLEAR, 0, 0);
      send(KIND_READ_OUT, 0, 0);
      drain();

      while (sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               build_list($urandom_range(1, 18));
               send(KIND_READ_OUT, $urandom_range(0, 31), pick_value());
            end
            4, 5, 6: begin
               repeat ($urandom_range(5, 10)) begin
                  if ($urandom_range(0, 4) == 0)
                     send(kind_type'($urandom_range(0, 7)), $urandom_range(0, 31),
                          pick_value());
                  else
                     send(kind_type'($urandom_range(0, 6)), $urandom_range(0, 17),
                          pick_value());
               end
            end
            7: begin
               build_list(CAPACITY);
               send(KIND_INSERT_AT, CAPACITY, pick_value());
               send(KIND_INSERT_AT, CAPACITY + 1, pick_value());
               send(KIND_INSERT_FRONT, 0, pick_value());
               send(KIND_READ_OUT, 0, 0);
               send(KIND_DELETE_AT, CAPACITY - 1, 0);
               send(KIND_DELETE_AT, CAPACITY - 1, 0);
               send(KIND_INSERT_AT, $urandom_range(0, CAPACITY - 1), pick_value());
               send(KIND_READ_OUT, 0, 0);
            end
            8: begin
               drain();
               send(kind_type'($urandom_range(0, 7)), $urandom_range(0, 17), pick_value());
            end
            default: begin
               repeat ($urandom_range(2, 6))
                  send(kind_type'($urandom_range(0, 7)), $urandom_range(0, 31),
                       pick_value());
            end
         endcase
      end

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
